[rtl/lrufr_pkg.sv]
// Package for the LRU frame replacer: sizes, op codes and interface structs.
`timescale 1ns / 1ps

package lrufr_pkg;

	// Table geometry
	localparam int CAPACITY   = 16;
	localparam int FRAME_BITS = 16;

	// Fixed field widths of the stream and configuration ports
	localparam int FRAME_W = 16;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 5;
	localparam int OCC_W   = 5;

	// Derived widths
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int WIDE_W = (FRAME_BITS > FRAME_W) ? FRAME_BITS : FRAME_W;

	typedef logic [FRAME_BITS-1:0] id_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_VICTIM = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Request presented to the table
	typedef struct packed {
		logic valid;
		op_t  op;
		id_t  id;
	} req_t;

	// Result of one request
	typedef struct packed {
		logic victim_valid;
		id_t  victim_id;
		cnt_t occupancy;
	} rsp_t;

endpackage

[rtl/lrufr_table.sv]
// Recency-ordered frame table: combinational associative lookup, compaction and append, registered per valid request.
`timescale 1ns / 1ps

module lrufr_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lrufr_pkg::CFG_W-1:0] max_entries,
	input  lrufr_pkg::req_t          req,
	output lrufr_pkg::rsp_t          rsp
);
	import lrufr_pkg::*;

	id_t  entry_q [CAPACITY];
	id_t  entry_n [CAPACITY];
	cnt_t count_q;
	cnt_t count_n;

	logic [CAPACITY-1:0] match;
	logic                hit;
	cnt_t                pos;

	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] count_w;
	logic [CMP_W-1:0] kept;

	cnt_t             gap;
	cnt_t             shift_by;
	logic             wr_en;
	cnt_t             wr_pos;
	logic [CNT_W:0]   src;

	// Compare every held entry against the request id at once
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (entry_q[i] == req.id);
		end
		// First match wins; ids are distinct so at most one is set
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				pos = CNT_W'(i);
			end
		end
	end

	// Effective limit: zero acts as one, saturate at capacity
	always_comb begin
		if (max_entries == '0) begin
			lim = CMP_W'(1);
		end else if (CMP_W'(max_entries) > CMP_W'(CAPACITY)) begin
			lim = CMP_W'(CAPACITY);
		end else begin
			lim = CMP_W'(max_entries);
		end
		count_w = CMP_W'(count_q);
		kept    = (count_w >= lim) ? (lim - CMP_W'(1)) : count_w;
	end

	// Decode the request into a shift from a gap position plus an optional append
	always_comb begin
		gap              = '0;
		shift_by         = '0;
		wr_en            = 1'b0;
		wr_pos           = '0;
		count_n          = count_q;
		rsp.victim_valid = 1'b0;
		rsp.victim_id    = '0;
		unique case (req.op)
			OP_VICTIM: begin
				if (count_q != '0) begin
					rsp.victim_valid = 1'b1;
					rsp.victim_id    = entry_q[0];
					shift_by         = CNT_W'(1);
					count_n          = count_q - CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (hit) begin
					gap      = pos;
					shift_by = CNT_W'(1);
					wr_en    = 1'b1;
					wr_pos   = count_q - CNT_W'(1);
				end else begin
					// Drop the oldest ids until one slot is free under the limit
					shift_by = count_q - CNT_W'(kept);
					wr_en    = 1'b1;
					wr_pos   = CNT_W'(kept);
					count_n  = CNT_W'(kept) + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					gap      = pos;
					shift_by = CNT_W'(1);
					count_n  = count_q - CNT_W'(1);
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
		rsp.occupancy = count_n;
	end

	// Close the gap toward the oldest end, then place the appended id
	always_comb begin
		src = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			src        = (CNT_W + 1)'(i) + (CNT_W + 1)'(shift_by);
			entry_n[i] = entry_q[i];
			if ((CNT_W'(i) >= gap) && (src < (CNT_W + 1)'(CAPACITY))) begin
				entry_n[i] = entry_q[src[IDX_W-1:0]];
			end
			if (wr_en && (wr_pos == CNT_W'(i))) begin
				entry_n[i] = req.id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			entry_q <= entry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req.valid) begin
			count_q <= count_n;
		end
	end

endmodule

[rtl/lru_frame_replacer_top.sv]
// Top level of the LRU frame replacer: stream ports, input and result registers.
`timescale 1ns / 1ps

// LRU frame replacer.
// Holds up to max_entries distinct frame ids ordered from least to most
// recently used. Each transaction on the slave stream is one request:
//   s_axis_tuser = op (victim, insert/touch, remove, or no-op),
//   s_axis_tdata = frame id.
// Each request produces exactly one result transaction on the master stream:
//   m_axis_tuser = victim_valid, m_axis_tdata = victim frame and occupancy.
// A request accepted into the input register is applied to the table as
// its result is registered, once the result register is free.
// Throughput is one request per cycle while the receiver keeps up; the
// combinational associative compare and shift of the table allow it.
// When the receiver stalls, the result holds in the output register and the
// pending request holds in the input register; tready drops only once both
// are full. Reset empties the list (occupancy 0) and sets max_entries to 16;
// table contents are not cleared since only held positions are ever read.
// Write cfg_wdata with cfg_we only while no transaction is outstanding.
module lru_frame_replacer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,      // max_entries
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] frame
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] victim_frame, [20:16] occupancy, rest 0
	output logic        m_axis_tuser    // [0] victim_valid
);
	import lrufr_pkg::*;

	logic [CFG_W-1:0]  max_entries_q;
	logic              valid_s1;
	op_t               op_s1;
	id_t               id_s1;
	logic              out_valid_q;
	rsp_t              rsp_q;
	rsp_t              rsp;
	req_t              req;
	logic              fire;
	logic [WIDE_W-1:0] frame_wide;
	logic [WIDE_W-1:0] victim_wide;
	logic [CMP_W-1:0]  occ_wide;

	// Advance the input register into the table whenever the result slot frees up
	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	// Keep only the low FRAME_BITS bits of the incoming id
	assign frame_wide = WIDE_W'(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= CFG_W'(16);
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= op_t'(s_axis_tuser);
			id_s1 <= frame_wide[FRAME_BITS-1:0];
		end
	end

	always_comb begin
		req.valid = fire;
		req.op    = op_s1;
		req.id    = id_s1;
	end

	lrufr_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_entries (max_entries_q),
		.req         (req),
		.rsp         (rsp)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp;
		end
	end

	assign victim_wide   = WIDE_W'(rsp_q.victim_id);
	assign occ_wide      = CMP_W'(rsp_q.occupancy);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = rsp_q.victim_valid;
	assign m_axis_tdata  = {3'b000, occ_wide[OCC_W-1:0], victim_wide[FRAME_W-1:0]};

endmodule

[tb/tb.sv]
// Self-checking testbench for the LRU frame replacer, with a recency-list scoreboard.
`timescale 1ns / 1ps

module tb;
	import lrufr_pkg::*;

	// Scoreboard: mirrors the recency list and holds the results still due
	class recency_tracker;
		id_t         order[CAPACITY];
		int unsigned held;
		logic [4:0]  max_entries;
		rsp_t        due_results[$];
		int unsigned errors;

		function new();
			max_entries = 5'd16;
			held = 0;
			errors = 0;
		endfunction

		function void write_limit(input logic [4:0] value);
			max_entries = value;
		endfunction

		function int unsigned limit_now();
			int unsigned lim;
			lim = max_entries;
			if (lim == 0)
				lim = 1;
			if (lim > CAPACITY)
				lim = CAPACITY;
			return lim;
		endfunction

		// Delete one entry and close the gap toward the least-recent end
		function void drop_at(input int unsigned pos);
			int unsigned i;
			if (pos >= held)
				return;
			for (i = pos; i + 1 < held; i++)
				order[i] = order[i + 1];
			held--;
		endfunction

		function int unsigned find_id(input id_t id);
			int unsigned i;
			for (i = 0; i < held; i++)
				if (order[i] == id)
					return i;
			return held;
		endfunction

		function void append_id(input id_t id);
			if (held < CAPACITY) begin
				order[held] = id;
				held++;
			end
		endfunction

		function int unsigned due_count();
			return due_results.size();
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void note_request(input op_t op, input logic [FRAME_W-1:0] frame);
			id_t         id;
			int unsigned pos;
			int unsigned lim;
			rsp_t        r;
			id = id_t'(frame);
			r = '0;
			case (op)
				OP_VICTIM: begin
					if (held > 0) begin
						r.victim_valid = 1'b1;
						r.victim_id = order[0];
						drop_at(0);
					end
				end
				OP_INSERT: begin
					pos = find_id(id);
					if (pos < held) begin
						drop_at(pos);
						append_id(id);
					end else begin
						lim = limit_now();
						while (held >= lim)
							drop_at(0);
						append_id(id);
					end
				end
				OP_REMOVE: begin
					pos = find_id(id);
					if (pos < held)
						drop_at(pos);
				end
				default: ;
			endcase
			r.occupancy = cnt_t'(held);
			due_results.push_back(r);
		endfunction

		function void check_result(input logic valid_bit, input logic [23:0] data);
			rsp_t r;
			if (due_results.size() == 0) begin
				$error("result transaction with no request outstanding: tdata %h", data);
				errors++;
				return;
			end
			r = due_results.pop_front();
			if (valid_bit !== r.victim_valid) begin
				$error("victim_valid: expected %0d, got %0d", r.victim_valid, valid_bit);
				errors++;
			end
			if (data[15:0] !== 16'(r.victim_id)) begin
				$error("victim_frame: expected %h, got %h", r.victim_id, data[15:0]);
				errors++;
			end
			if (data[20:16] !== 5'(r.occupancy)) begin
				$error("occupancy: expected %0d, got %0d", r.occupancy, data[20:16]);
				errors++;
			end
			if (data[23:21] !== 3'b000) begin
				$error("tdata padding: expected 0, got %h", data[23:21]);
				errors++;
			end
		endfunction
	endclass

	// Cycles with no transaction on either stream before the run is abandoned
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned POOL_SIZE   = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = 5'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;
	logic [1:0]  s_axis_tuser = 2'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	recency_tracker tracker = new();

	// Idle rates in percent of cycles, changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	lru_frame_replacer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [15:0] frame
		.s_axis_tuser  (s_axis_tuser),   // [1:0] op
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [15:0] victim_frame, [20:16] occupancy, rest 0
		.m_axis_tuser  (m_axis_tuser)    // [0] victim_valid
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random on the falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check each result transaction and watch for a hung pipeline
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tuser, m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one request, idling first at random; return on the falling edge after the
	// transaction, with tvalid still high so back-to-back requests never drop it
	task automatic send_req(input op_t op, input logic [15:0] frame);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= frame;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_request(op, frame);
		@(negedge clk);
	endtask

	// Drop tvalid and hold until every result is back, then let the pipeline settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.due_count() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write max_entries with the block idle
	task automatic set_limit(input logic [4:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.write_limit(value);
	endtask

	// Short directed sequence: empty list, touch, remove miss and hit, eviction,
	// limit of zero and a limit lowered below the occupancy
	task automatic run_directed();
		send_req(OP_VICTIM, 16'hFFFF);   // victim on an empty list
		send_req(OP_REMOVE, 16'h1234);   // remove with nothing held
		send_req(OP_NOP, 16'hFFFF);
		send_req(OP_INSERT, 16'h0000);
		send_req(OP_INSERT, 16'hFFFF);
		send_req(OP_INSERT, 16'h8001);
		send_req(OP_INSERT, 16'h0000);   // touch: move to most-recent end
		send_req(OP_REMOVE, 16'h5555);   // id not held
		send_req(OP_REMOVE, 16'hFFFF);
		send_req(OP_NOP, 16'h0000);
		send_req(OP_VICTIM, 16'h0000);
		send_req(OP_VICTIM, 16'h0000);
		send_req(OP_VICTIM, 16'h0000);   // empty again
		set_limit(5'd2);
		send_req(OP_INSERT, 16'h0011);
		send_req(OP_INSERT, 16'h0022);
		send_req(OP_INSERT, 16'h0033);   // full: oldest goes
		send_req(OP_INSERT, 16'h0022);   // touch never evicts
		send_req(OP_INSERT, 16'h0044);
		set_limit(5'd0);                 // zero acts as one, below occupancy
		send_req(OP_INSERT, 16'h0022);   // touch at lowered limit keeps both
		send_req(OP_INSERT, 16'h00AA);   // new id drops both older entries
		send_req(OP_VICTIM, 16'h0000);
	endtask

	// Random phase: mostly requests on a small id pool so touches and removes hit,
	// with a share of wide random ids
	task automatic run_phase(input logic [4:0] limit, input int unsigned count,
			input int unsigned send_pct, input int unsigned recv_pct);
		logic [15:0] pool[POOL_SIZE];
		logic [15:0] frame;
		int unsigned pick;
		op_t         op;
		set_limit(limit);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		foreach (pool[i])
			pool[i] = 16'($urandom);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = OP_INSERT;
			else if (pick < 65)
				op = OP_REMOVE;
			else if (pick < 88)
				op = OP_VICTIM;
			else
				op = OP_NOP;
			if ($urandom_range(9) == 0)
				frame = 16'($urandom);
			else
				frame = pool[$urandom_range(POOL_SIZE - 1)];
			send_req(op, frame);
		end
	endtask

	initial begin
		logic [4:0] limits[9];
		limits = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd7, 5'd16, 5'd17, 5'd4, 5'd12};
		// Hold reset, then release it on a falling edge
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 14;
		recv_idle_pct = 51;
		run_directed();
		// Cycle the idle pattern across phases: sender light and receiver heavy,
		// then swapped, then none
		foreach (limits[p]) begin
			case (p % 3)
				0: run_phase(limits[p], 200, 14, 51);
				1: run_phase(limits[p], 200, 51, 14);
				default: run_phase(limits[p], 200, 0, 0);
			endcase
		end
		wait_drained();
		repeat (5) @(negedge clk);
		if (tracker.errors == 0 && tracker.due_count() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[lru_frame_replacer_top.f]
rtl/lrufr_pkg.sv
rtl/lrufr_table.sv
rtl/lru_frame_replacer_top.sv
tb/tb.sv
